// File: design/cm4i_pkg.sv
// shared types, constants and index functions for the 4x4 matrix inverse core
package cm4i_pkg;

    localparam int ENT_W = 32;   // entry width
    localparam int CW    = 98;   // signed cofactor width
    localparam int MAG_W = 96;   // cofactor magnitude width
    localparam int DETW  = 132;  // signed determinant width
    localparam int QW    = 33;   // quotient bits kept
    localparam int USERW = 6;    // tuser width

    localparam logic [ENT_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [ENT_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_COF,
        ST_DET,
        ST_DIVRD,
        ST_DIVLD,
        ST_DIVIT,
        ST_EMIT
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACC_CLR,
        OP_X,
        OP_XY,
        OP_Z,
        OP_PLO,
        OP_PHI,
        OP_PACC,
        OP_DET_CLR,
        OP_DLOAD,
        OP_DM0,
        OP_DM1,
        OP_DM2,
        OP_DM3,
        OP_VLOAD,
        OP_VSTEP,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       neg;
        logic       first;
        logic       last;
        logic [3:0] pos;
        logic       ent_we;
        logic [3:0] ent_waddr;
        logic [3:0] ent_raddr;
        logic       cof_we;
        logic [3:0] cof_waddr;
        logic [3:0] cof_raddr;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

    // column picked by permutation t for minor row r
    function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] r);
        logic [5:0] p;
        case (t)
            3'd0:    p = {2'd2, 2'd1, 2'd0};
            3'd1:    p = {2'd0, 2'd2, 2'd1};
            3'd2:    p = {2'd1, 2'd0, 2'd2};
            3'd3:    p = {2'd1, 2'd2, 2'd0};
            3'd4:    p = {2'd0, 2'd1, 2'd2};
            default: p = {2'd2, 2'd0, 2'd1};
        endcase
        case (r)
            2'd0:    return p[1:0];
            2'd1:    return p[3:2];
            default: return p[5:4];
        endcase
    endfunction

    // entry address of factor r of term t of cofactor s
    function automatic logic [3:0] cof_addr(input logic [3:0] s, input logic [2:0] t,
                                            input logic [1:0] r);
        logic [1:0] p;
        logic [1:0] q;
        logic [1:0] j;
        logic [1:0] row;
        logic [1:0] col;
        p   = s[3:2];
        q   = s[1:0];
        row = (r < q) ? r : r + 2'd1;
        j   = perm_col(t, r);
        col = (j < p) ? j : j + 2'd1;
        return {row, col};
    endfunction

    // term sign: odd permutation xor checkerboard sign
    function automatic logic term_neg(input logic [3:0] s, input logic [2:0] t);
        return (t >= 3'd3) ^ s[2] ^ s[0];
    endfunction

endpackage

// File: design/cm4i_ram.sv
// generic single write port ram with registered read
module cm4i_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/cm4i_ctrl.sv
// sequencer for load, cofactor, determinant, division and output phases
module cm4i_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  cm4i_pkg::sts_t  sts,
    output cm4i_pkg::cmd_t  cmd
);
    import cm4i_pkg::*;

    state_t     state_reg, state_next;
    logic [3:0] load_reg, load_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [2:0] term_reg, term_next;
    logic [2:0] step_reg, step_next;
    logic [5:0] bit_reg, bit_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            load_reg  <= '0;
            cnt_reg   <= '0;
            term_reg  <= '0;
            step_reg  <= '0;
            bit_reg   <= '0;
        end else begin
            state_reg <= state_next;
            load_reg  <= load_next;
            cnt_reg   <= cnt_next;
            term_reg  <= term_next;
            step_reg  <= step_next;
            bit_reg   <= bit_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        load_next  = load_reg;
        cnt_next   = cnt_reg;
        term_next  = term_reg;
        step_next  = step_reg;
        bit_next   = bit_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.op     = OP_NONE;
        case (state_reg)
            ST_LOAD: begin
                s_tready      = 1'b1;
                cmd.ent_waddr = load_reg;
                if (s_tvalid) begin
                    cmd.ent_we = 1'b1;
                    load_next  = load_reg + 4'd1;
                    if (load_reg == 4'd15) begin
                        state_next = ST_COF;
                        cnt_next   = '0;
                        term_next  = '0;
                        step_next  = '0;
                    end
                end
            end
            ST_COF: begin
                cmd.neg   = term_neg(cnt_reg, term_reg);
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd0: begin
                        cmd.ent_raddr = cof_addr(cnt_reg, term_reg, 2'd0);
                        cmd.op = (term_reg == 3'd0) ? OP_ACC_CLR : OP_NONE;
                    end
                    3'd1: begin
                        cmd.ent_raddr = cof_addr(cnt_reg, term_reg, 2'd1);
                        cmd.op = OP_X;
                    end
                    3'd2: begin
                        cmd.ent_raddr = cof_addr(cnt_reg, term_reg, 2'd2);
                        cmd.op = OP_XY;
                    end
                    3'd3: cmd.op = OP_Z;
                    3'd4: cmd.op = OP_PLO;
                    3'd5: cmd.op = OP_PHI;
                    default: begin
                        cmd.op    = OP_PACC;
                        step_next = '0;
                        if (term_reg == 3'd5) begin
                            cmd.cof_we    = 1'b1;
                            cmd.cof_waddr = cnt_reg;
                            term_next     = '0;
                            cnt_next      = cnt_reg + 4'd1;
                            if (cnt_reg == 4'd15) begin
                                state_next = ST_DET;
                            end
                        end else begin
                            term_next = term_reg + 3'd1;
                        end
                    end
                endcase
            end
            ST_DET: begin
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd0: begin
                        cmd.cof_raddr = {cnt_reg[1:0], 2'b00};
                        cmd.ent_raddr = {2'b00, cnt_reg[1:0]};
                        cmd.op = (cnt_reg[1:0] == 2'd0) ? OP_DET_CLR : OP_NONE;
                    end
                    3'd1: cmd.op = OP_DLOAD;
                    3'd2: cmd.op = OP_DM0;
                    3'd3: cmd.op = OP_DM1;
                    3'd4: cmd.op = OP_DM2;
                    default: begin
                        cmd.op    = OP_DM3;
                        step_next = '0;
                        if (cnt_reg[1:0] == 2'd3) begin
                            cnt_next   = '0;
                            state_next = ST_DIVRD;
                        end else begin
                            cnt_next = cnt_reg + 4'd1;
                        end
                    end
                endcase
            end
            ST_DIVRD: begin
                cmd.cof_raddr = cnt_reg;
                state_next    = ST_DIVLD;
            end
            ST_DIVLD: begin
                cmd.op     = OP_VLOAD;
                bit_next   = '0;
                state_next = ST_DIVIT;
            end
            ST_DIVIT: begin
                cmd.op    = OP_VSTEP;
                cmd.first = (bit_reg == 6'd0);
                if (bit_reg == 6'(QW)) begin
                    state_next = ST_EMIT;
                end else begin
                    bit_next = bit_reg + 6'd1;
                end
            end
            ST_EMIT: begin
                cmd.pos  = cnt_reg;
                cmd.last = (cnt_reg == 4'd15);
                if (sts.out_free) begin
                    cmd.op   = OP_OUT;
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15) begin
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_DIVRD;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

endmodule

// File: design/cm4i_dpath.sv
// datapath: entry and cofactor rams, shared multiplier, accumulators, divider, output register
module cm4i_dpath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cm4i_pkg::cmd_t               cmd,
    output cm4i_pkg::sts_t               sts,
    input  logic [cm4i_pkg::ENT_W-1:0]   s_tdata,
    input  logic                         m_tready,
    output logic                         m_tvalid,
    output logic [cm4i_pkg::ENT_W-1:0]   m_tdata,
    output logic [cm4i_pkg::USERW-1:0]   m_tuser,
    output logic                         m_tlast
);
    import cm4i_pkg::*;

    localparam int NUMW = MAG_W + 2 * FRAC_BITS;
    localparam int DENW = DETW + QW;
    localparam int DIVW = ((NUMW > DENW) ? NUMW : DENW) + 1;

    function automatic logic [ENT_W-1:0] mag32(input logic [ENT_W-1:0] x);
        return x[ENT_W-1] ? (~x + 32'd1) : x;
    endfunction

    logic [ENT_W-1:0] ent_rd;
    logic [CW-1:0]    cof_rd;
    logic [CW-1:0]    acc_reg;
    logic [CW-1:0]    acc_addend;
    logic [CW-1:0]    acc_next;

    cm4i_ram #(.WIDTH(ENT_W), .DEPTH(16)) u_ent_ram (
        .aclk  (aclk),
        .we    (cmd.ent_we),
        .waddr (cmd.ent_waddr),
        .wdata (s_tdata),
        .raddr (cmd.ent_raddr),
        .rdata (ent_rd)
    );

    cm4i_ram #(.WIDTH(CW), .DEPTH(16)) u_cof_ram (
        .aclk  (aclk),
        .we    (cmd.cof_we),
        .waddr (cmd.cof_waddr),
        .wdata (acc_next),
        .raddr (cmd.cof_raddr),
        .rdata (cof_rd)
    );

    logic [ENT_W-1:0] xm_reg, zm_reg, am_reg;
    logic             sgn_reg, dsgn_reg;
    logic [63:0]      p_reg, mul_reg;
    logic [MAG_W-1:0] cm_reg;
    logic [DETW-1:0]  det_reg, det_addend, det_next, mdet;
    logic [DIVW-1:0]  num_reg, den_reg, diff;
    logic             ge;
    logic [QW-1:0]    q_reg;
    logic             ovf_reg, nneg_reg;
    logic [ENT_W-1:0] mul_a, mul_b;
    logic [63:0]      mul_res;
    logic [CW-1:0]    cof_mag;
    logic             det_neg, singular;
    logic [ENT_W-1:0] res_val;
    logic             res_clip;
    logic             valid_reg;
    logic [ENT_W-1:0] data_reg;
    logic [USERW-1:0] user_reg;
    logic             last_reg;

    // shared 32x32 unsigned multiplier
    always_comb begin
        case (cmd.op)
            OP_XY:   begin mul_a = xm_reg;        mul_b = mag32(ent_rd); end
            OP_PLO:  begin mul_a = p_reg[31:0];   mul_b = zm_reg;        end
            OP_PHI:  begin mul_a = p_reg[63:32];  mul_b = zm_reg;        end
            OP_DM0:  begin mul_a = cm_reg[31:0];  mul_b = am_reg;        end
            OP_DM1:  begin mul_a = cm_reg[63:32]; mul_b = am_reg;        end
            OP_DM2:  begin mul_a = cm_reg[95:64]; mul_b = am_reg;        end
            default: begin mul_a = '0;            mul_b = '0;            end
        endcase
    end
    assign mul_res = 64'(mul_a) * 64'(mul_b);

    // signed accumulate by conditional invert and carry in
    assign acc_addend = (cmd.op == OP_PACC) ? {2'b00, mul_reg, 32'd0} : CW'(mul_reg);
    assign acc_next   = acc_reg + (acc_addend ^ {CW{sgn_reg}}) + CW'(sgn_reg);

    always_comb begin
        case (cmd.op)
            OP_DM2:  det_addend = DETW'({mul_reg, 32'd0});
            OP_DM3:  det_addend = DETW'({mul_reg, 64'd0});
            default: det_addend = DETW'(mul_reg);
        endcase
    end
    assign det_next = det_reg + (det_addend ^ {DETW{dsgn_reg}}) + DETW'(dsgn_reg);
    assign det_neg  = det_reg[DETW-1];
    assign mdet     = det_neg ? (~det_reg + DETW'(1)) : det_reg;
    assign singular = (det_reg == '0);
    assign cof_mag  = cof_rd[CW-1] ? (~cof_rd + CW'(1)) : cof_rd;

    assign ge   = (num_reg >= den_reg);
    assign diff = num_reg - den_reg;

    // sign, saturation and singular override
    always_comb begin
        if (singular) begin
            res_val  = '0;
            res_clip = 1'b0;
        end else if (nneg_reg) begin
            res_clip = ovf_reg | q_reg[32] | (q_reg[31] & (|q_reg[30:0]));
            res_val  = res_clip ? SAT_MIN : (~q_reg[31:0] + 32'd1);
        end else begin
            res_clip = ovf_reg | q_reg[32] | q_reg[31];
            res_val  = res_clip ? SAT_MAX : q_reg[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_ACC_CLR: acc_reg <= '0;
            OP_X: begin
                xm_reg  <= mag32(ent_rd);
                sgn_reg <= ent_rd[ENT_W-1] ^ cmd.neg;
            end
            OP_XY: begin
                mul_reg <= mul_res;
                sgn_reg <= sgn_reg ^ ent_rd[ENT_W-1];
            end
            OP_Z: begin
                zm_reg  <= mag32(ent_rd);
                sgn_reg <= sgn_reg ^ ent_rd[ENT_W-1];
                p_reg   <= mul_reg;
            end
            OP_PLO: mul_reg <= mul_res;
            OP_PHI: begin
                acc_reg <= acc_next;
                mul_reg <= mul_res;
            end
            OP_PACC: acc_reg <= acc_next;
            OP_DET_CLR: det_reg <= '0;
            OP_DLOAD: begin
                cm_reg   <= cof_mag[MAG_W-1:0];
                am_reg   <= mag32(ent_rd);
                dsgn_reg <= cof_rd[CW-1] ^ ent_rd[ENT_W-1];
            end
            OP_DM0: mul_reg <= mul_res;
            OP_DM1, OP_DM2: begin
                det_reg <= det_next;
                mul_reg <= mul_res;
            end
            OP_DM3: det_reg <= det_next;
            OP_VLOAD: begin
                num_reg  <= DIVW'(cof_mag[MAG_W-1:0]) << (2 * FRAC_BITS);
                den_reg  <= DIVW'(mdet) << QW;
                nneg_reg <= cof_rd[CW-1] ^ det_neg;
                q_reg    <= '0;
                ovf_reg  <= 1'b0;
            end
            OP_VSTEP: begin
                den_reg <= den_reg >> 1;
                if (cmd.first) begin
                    ovf_reg <= ge;
                end else begin
                    if (ge) begin
                        num_reg <= diff;
                    end
                    q_reg <= {q_reg[QW-2:0], ge};
                end
            end
            default: ;
        endcase
    end

    // output register, holds under stall
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.op == OP_OUT) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_OUT) begin
            data_reg <= res_val;
            user_reg <= {res_clip, singular, cmd.pos};
            last_reg <= cmd.last;
        end
    end

    assign sts.out_free = !valid_reg || m_tready;
    assign m_tvalid     = valid_reg;
    assign m_tdata      = data_reg;
    assign m_tuser      = user_reg;
    assign m_tlast      = last_reg;

endmodule

// File: design/matrix4_inverse_core.sv
// top level of the 4x4 matrix inverse core (cofactors, adjugate, determinant divide)
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata[31:0] entry_value
// m_*       out  m_tvalid/m_tready  tdata[31:0] inverse_value, tuser[5:0], tlast last_entry
//
// phases: 16 load transactions at one per cycle, then the cofactors
//   (16 cofactors x 6 terms x 7 steps on the one 32x32 multiplier), the
//   determinant, and for each result the restoring divider (34 steps)
// reset clears the sequencer and the output valid; a partial load is dropped
// m_tready low holds the current result; the divider waits before the next one
// after the sixteenth result goes out the block takes the next matrix at once
module matrix4_inverse_core #(
    parameter int FRAC_BITS = 16   // fraction bits of the fixed point format
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] entry_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] inverse_value
    output logic [5:0]  m_tuser,   // [3:0] entry_position, [4] singular, [5] clipped
    output logic        m_tlast    // last_entry
);
    import cm4i_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer: counts loads, steps terms, division bits and results
    cm4i_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // arithmetic and storage
    cm4i_dpath #(.FRAC_BITS(FRAC_BITS)) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: design/cm4i_chk.sv
// port level checker for the matrix inverse core, bound to the top level
module cm4i_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [5:0]  m_tuser,
    input logic        m_tlast
);

    // stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // singular results are zero and not clipped
    a_sing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[4] |-> m_tdata == 32'd0 && !m_tuser[5])
        else $error("singular result not zero");

    // clipped results sit at a range limit
    a_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[5] |-> m_tdata == 32'h7FFF_FFFF || m_tdata == 32'h8000_0000)
        else $error("clipped result off limit");

    // last flag only on position fifteen
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tlast == (m_tuser[3:0] == 4'd15))
        else $error("last flag mismatch");

endmodule

bind matrix4_inverse_core cm4i_chk u_cm4i_chk (.*);
